>>> src/tbg_pkg.sv
// tbg_pkg: shared types, constants and a helper function of the tiled background fetch
// used by the front, queue, back and top modules of the block, depends on nothing else
package tbg_pkg;

  // memory geometry
  localparam int VIDEO_WORDS     = 32768;
  localparam int PALETTE_ENTRIES = 256;
  localparam int VA_W            = $clog2(VIDEO_WORDS);
  localparam int PA_W            = $clog2(PALETTE_ENTRIES);

  // command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QP_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QC_W   = $clog2(QDEPTH + 1);

  // input opcodes
  localparam logic [1:0] OP_RENDER = 2'd0;
  localparam logic [1:0] OP_VID_WR = 2'd1;
  localparam logic [1:0] OP_PAL_WR = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_LAYER_CONTROL = 2'd0;
  localparam logic [1:0] REG_SCROLL_X      = 2'd1;
  localparam logic [1:0] REG_SCROLL_Y      = 2'd2;
  localparam logic [1:0] REG_MOSAIC_SIZE   = 2'd3;

  // layer control bit positions
  localparam int LC_CHAR_LO   = 2;
  localparam int LC_MOSAIC    = 6;
  localparam int LC_EIGHT     = 7;
  localparam int LC_SCREEN_LO = 8;
  localparam int LC_WIDE      = 14;
  localparam int LC_TALL      = 15;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [14:0] mem_address;
    logic [15:0] write_value;
    logic [7:0]  column;
    logic [7:0]  screen_line;
  } tbg_in_t;

  typedef struct packed {
    logic [14:0] color;
    logic        opaque;
  } tbg_out_t;

  typedef struct packed {
    logic [15:0] layer_control;
    logic [8:0]  scroll_x;
    logic [8:0]  scroll_y;
    logic [7:0]  mosaic_size;
  } tbg_cfg_t;

  typedef enum logic [1:0] {
    CMD_RENDER,
    CMD_VID_WR,
    CMD_PAL_WR
  } tbg_cmd_kind_e;

  // render: addr is the map entry address, data holds {ty, tx} in its low bits
  typedef struct packed {
    tbg_cmd_kind_e   kind;
    logic [VA_W-1:0] addr;
    logic [15:0]     data;
  } tbg_cmd_t;

  typedef struct packed {
    logic            full;
    logic            empty;
    logic [QC_W-1:0] count;
  } tbg_q_status_t;

  typedef struct packed {
    logic holding;
  } tbg_fr_status_t;

  typedef struct packed {
    logic in_pal;
  } tbg_bk_status_t;

  typedef enum logic [1:0] {
    FR_EMPTY,
    FR_DIV,
    FR_READY
  } tbg_fr_state_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MAP,
    BK_TILE,
    BK_PAL
  } tbg_bk_state_e;

  // one restoring remainder step, rem stays below m (m at most 16)
  function automatic logic [4:0] mosaic_step(input logic [4:0] rem, input logic b,
                                             input logic [4:0] m);
    logic [4:0] t;
    begin
      t = {rem[3:0], b};
      if (t >= m) begin
        t = t - m;
      end
      return t;
    end
  endfunction

endpackage

>>> src/tbg_ram.sv
// tbg_ram: generic single write port, single read port memory with registered read
// no package dependencies
module tbg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/tbg_queue.sv
// tbg_queue: short command queue between the front and the back
// depends on tbg_pkg
module tbg_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  tbg_pkg::tbg_cmd_t      cmd_i,
  input  logic                   pop_i,
  output tbg_pkg::tbg_cmd_t      cmd_o,
  output tbg_pkg::tbg_q_status_t status_o
);

  tbg_pkg::tbg_cmd_t                 mem_q [tbg_pkg::QDEPTH];
  logic [tbg_pkg::QP_W-1:0]          wr_ptr_q, wr_ptr_d;
  logic [tbg_pkg::QP_W-1:0]          rd_ptr_q, rd_ptr_d;
  logic [tbg_pkg::QC_W-1:0]          count_q, count_d;

  localparam logic [tbg_pkg::QP_W-1:0] LastPtr = tbg_pkg::QP_W'(tbg_pkg::QDEPTH - 1);
  localparam logic [tbg_pkg::QC_W-1:0] FullCnt = tbg_pkg::QC_W'(tbg_pkg::QDEPTH);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign cmd_o          = mem_q[rd_ptr_q];
  assign status_o.full  = (count_q == FullCnt);
  assign status_o.empty = (count_q == '0);
  assign status_o.count = count_q;

endmodule

>>> src/tbg_front.sv
// tbg_front: accepts items, classifies them, runs mosaic snapping and builds map addresses
// depends on tbg_pkg; feeds tbg_queue
module tbg_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  tbg_pkg::tbg_cfg_t       cfg_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  tbg_pkg::tbg_in_t        in_item_i,
  input  tbg_pkg::tbg_q_status_t  q_status_i,
  output logic                    q_push_o,
  output tbg_pkg::tbg_cmd_t       q_cmd_o,
  output tbg_pkg::tbg_fr_status_t status_o
);

  tbg_pkg::tbg_fr_state_e  state_q, state_d;
  tbg_pkg::tbg_cmd_kind_e  kind_q, kind_d;
  logic [1:0]              cnt_q, cnt_d;
  logic [4:0]              rem_x_q, rem_x_d, rem_y_q, rem_y_d;
  logic [14:0]             addr_q;
  logic [15:0]             data_q;
  logic [7:0]              x_q, y_q;

  logic        accept, push;
  logic [4:0]  mh, mv, rx1, rx2, ry1, ry2;
  logic [2:0]  hi_idx, lo_idx;
  logic [7:0]  xm, ym;
  logic [8:0]  xx, yy;
  logic        wide, tall;
  logic [1:0]  quad_x, quad_y, quad;
  logic [5:0]  map_hi;
  logic [15:0] map_full, wr_addr16;

  assign push       = (state_q == tbg_pkg::FR_READY) && !q_status_i.full;
  assign in_stall_o = (state_q == tbg_pkg::FR_DIV) ||
                      ((state_q == tbg_pkg::FR_READY) && !push);
  assign accept     = in_valid_i && !in_stall_o;

  // mosaic remainder, two bits per cycle, msb first
  assign mh     = {1'b0, cfg_i.mosaic_size[3:0]} + 5'd1;
  assign mv     = {1'b0, cfg_i.mosaic_size[7:4]} + 5'd1;
  assign hi_idx = {~cnt_q, 1'b1};
  assign lo_idx = {~cnt_q, 1'b0};
  assign rx1    = tbg_pkg::mosaic_step(rem_x_q, x_q[hi_idx], mh);
  assign rx2    = tbg_pkg::mosaic_step(rx1, x_q[lo_idx], mh);
  assign ry1    = tbg_pkg::mosaic_step(rem_y_q, y_q[hi_idx], mv);
  assign ry2    = tbg_pkg::mosaic_step(ry1, y_q[lo_idx], mv);

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    cnt_d   = cnt_q;
    rem_x_d = rem_x_q;
    rem_y_d = rem_y_q;
    case (state_q)
      tbg_pkg::FR_EMPTY: begin
      end
      tbg_pkg::FR_DIV: begin
        rem_x_d = rx2;
        rem_y_d = ry2;
        cnt_d   = cnt_q + 2'd1;
        if (&cnt_q) begin
          state_d = tbg_pkg::FR_READY;
        end
      end
      tbg_pkg::FR_READY: begin
        if (push) begin
          state_d = tbg_pkg::FR_EMPTY;
        end
      end
      default: begin
        state_d = tbg_pkg::FR_EMPTY;
      end
    endcase
    if (accept) begin
      rem_x_d = '0;
      rem_y_d = '0;
      cnt_d   = '0;
      case (in_item_i.opcode)
        tbg_pkg::OP_RENDER: begin
          kind_d  = tbg_pkg::CMD_RENDER;
          state_d = cfg_i.layer_control[tbg_pkg::LC_MOSAIC] ? tbg_pkg::FR_DIV
                                                            : tbg_pkg::FR_READY;
        end
        tbg_pkg::OP_VID_WR: begin
          kind_d  = tbg_pkg::CMD_VID_WR;
          state_d = tbg_pkg::FR_READY;
        end
        tbg_pkg::OP_PAL_WR: begin
          kind_d  = tbg_pkg::CMD_PAL_WR;
          state_d = tbg_pkg::FR_READY;
        end
        default: begin
          // unused opcode, dropped without a result
          state_d = tbg_pkg::FR_EMPTY;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tbg_pkg::FR_EMPTY;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    rem_x_q <= rem_x_d;
    rem_y_q <= rem_y_d;
    if (accept) begin
      addr_q <= in_item_i.mem_address;
      data_q <= in_item_i.write_value;
      x_q    <= in_item_i.column;
      y_q    <= in_item_i.screen_line;
    end
  end

  // snapped position, scroll and quadrant select
  assign xm   = x_q - {3'b0, rem_x_q};
  assign ym   = y_q - {3'b0, rem_y_q};
  assign xx   = {1'b0, xm} + cfg_i.scroll_x;
  assign yy   = {1'b0, ym} + cfg_i.scroll_y;
  assign wide = cfg_i.layer_control[tbg_pkg::LC_WIDE];
  assign tall = cfg_i.layer_control[tbg_pkg::LC_TALL];

  assign quad_x   = {1'b0, wide & xx[8]};
  assign quad_y   = (tall & yy[8]) ? (wide ? 2'd2 : 2'd1) : 2'd0;
  assign quad     = quad_x + quad_y;
  assign map_hi   = {1'b0, cfg_i.layer_control[tbg_pkg::LC_SCREEN_LO +: 5]} + {4'b0, quad};
  assign map_full = {map_hi, yy[7:3], xx[7:3]};
  assign wr_addr16 = {1'b0, addr_q};

  always_comb begin
    q_cmd_o.kind = kind_q;
    if (kind_q == tbg_pkg::CMD_RENDER) begin
      q_cmd_o.addr = map_full[tbg_pkg::VA_W-1:0];
      q_cmd_o.data = {10'b0, yy[2:0], xx[2:0]};
    end else begin
      q_cmd_o.addr = wr_addr16[tbg_pkg::VA_W-1:0];
      q_cmd_o.data = data_q;
    end
  end

  assign q_push_o         = push;
  assign status_o.holding = (state_q != tbg_pkg::FR_EMPTY);

endmodule

>>> src/tbg_back.sv
// tbg_back: executes queued commands: memory writes and the map, tile, palette read chain
// depends on tbg_pkg and tbg_ram
module tbg_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  tbg_pkg::tbg_cfg_t       cfg_i,
  input  tbg_pkg::tbg_q_status_t  q_status_i,
  input  tbg_pkg::tbg_cmd_t       q_cmd_i,
  output logic                    q_pop_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output tbg_pkg::tbg_out_t       out_item_o,
  output tbg_pkg::tbg_bk_status_t status_o
);

  tbg_pkg::tbg_bk_state_e state_q, state_d;
  logic [2:0]             tx_q, ty_q;
  logic [3:0]             bank_q;
  logic                   nib_q, bsel_q, opaque_q;
  logic                   out_valid_q, out_valid_d;
  tbg_pkg::tbg_out_t      out_q;

  logic                      pop, load, eight;
  logic                      vid_we, vid_re, pal_we, pal_re;
  logic [tbg_pkg::VA_W-1:0]  vid_raddr;
  logic [15:0]               vid_rdata;
  logic [tbg_pkg::PA_W-1:0]  pal_raddr;
  logic [14:0]               pal_rdata;

  logic [9:0]  tile;
  logic [2:0]  tx_e, ty_e;
  logic [15:0] tile_off;
  logic [16:0] byte_addr;
  logic [7:0]  tbyte, pix;
  logic [3:0]  nibble;

  assign eight = cfg_i.layer_control[tbg_pkg::LC_EIGHT];
  assign pop   = (state_q == tbg_pkg::BK_IDLE) && !q_status_i.empty;
  assign load  = (state_q == tbg_pkg::BK_PAL) && (!out_valid_q || !out_stall_i);

  // map entry decode and tile byte address
  assign tile     = vid_rdata[9:0];
  assign tx_e     = tx_q ^ {3{vid_rdata[10]}};
  assign ty_e     = ty_q ^ {3{vid_rdata[11]}};
  assign tile_off = eight ? {tile, ty_e, tx_e} : {1'b0, tile, ty_e, tx_e[2:1]};
  assign byte_addr = {1'b0, cfg_i.layer_control[tbg_pkg::LC_CHAR_LO +: 2], 14'b0}
                   + {1'b0, tile_off};

  // pixel index from the tile halfword
  assign tbyte  = bsel_q ? vid_rdata[15:8] : vid_rdata[7:0];
  assign nibble = nib_q ? tbyte[7:4] : tbyte[3:0];
  assign pix    = eight ? tbyte : {bank_q, nibble};

  always_comb begin
    state_d   = state_q;
    vid_we    = 1'b0;
    vid_re    = 1'b0;
    pal_we    = 1'b0;
    pal_re    = 1'b0;
    vid_raddr = q_cmd_i.addr;
    pal_raddr = pix;
    case (state_q)
      tbg_pkg::BK_IDLE: begin
        if (pop) begin
          case (q_cmd_i.kind)
            tbg_pkg::CMD_VID_WR: vid_we = 1'b1;
            tbg_pkg::CMD_PAL_WR: pal_we = 1'b1;
            tbg_pkg::CMD_RENDER: begin
              vid_re  = 1'b1;
              state_d = tbg_pkg::BK_MAP;
            end
            default: begin
            end
          endcase
        end
      end
      tbg_pkg::BK_MAP: begin
        vid_re    = 1'b1;
        vid_raddr = byte_addr[tbg_pkg::VA_W:1];
        state_d   = tbg_pkg::BK_TILE;
      end
      tbg_pkg::BK_TILE: begin
        // transparent pixels skip the palette read
        pal_re  = eight ? (tbyte != 8'd0) : (nibble != 4'd0);
        state_d = tbg_pkg::BK_PAL;
      end
      tbg_pkg::BK_PAL: begin
        if (load) begin
          state_d = tbg_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = tbg_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tbg_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      tx_q <= q_cmd_i.data[2:0];
      ty_q <= q_cmd_i.data[5:3];
    end
    if (state_q == tbg_pkg::BK_MAP) begin
      bank_q <= vid_rdata[15:12];
      nib_q  <= tx_e[0];
      bsel_q <= byte_addr[0];
    end
    if (state_q == tbg_pkg::BK_TILE) begin
      opaque_q <= pal_re;
    end
    if (load) begin
      out_q.color  <= opaque_q ? pal_rdata : 15'd0;
      out_q.opaque <= opaque_q;
    end
  end

  tbg_ram #(
    .WIDTH (16),
    .DEPTH (tbg_pkg::VIDEO_WORDS)
  ) u_video_ram (
    .clk_i   (clk_i),
    .we_i    (vid_we),
    .waddr_i (q_cmd_i.addr),
    .wdata_i (q_cmd_i.data),
    .re_i    (vid_re),
    .raddr_i (vid_raddr),
    .rdata_o (vid_rdata)
  );

  tbg_ram #(
    .WIDTH (15),
    .DEPTH (tbg_pkg::PALETTE_ENTRIES)
  ) u_palette_ram (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (q_cmd_i.addr[tbg_pkg::PA_W-1:0]),
    .wdata_i (q_cmd_i.data[14:0]),
    .re_i    (pal_re),
    .raddr_i (pal_raddr),
    .rdata_o (pal_rdata)
  );

  assign q_pop_o         = pop;
  assign out_valid_o     = out_valid_q;
  assign out_item_o      = out_q;
  assign status_o.in_pal = (state_q == tbg_pkg::BK_PAL);

endmodule

>>> src/tiled_bg_pixel_fetch_core.sv
// tiled_bg_pixel_fetch_core: top level of the tiled background pixel fetch
// depends on tbg_pkg, tbg_front, tbg_queue, tbg_back (and tbg_ram through tbg_back)
//
// usage
// - input channel (in_valid_i / in_stall_o / in_item_i): one item per handshake, either
//   a render of a screen column and line, a video memory halfword write or a palette write
// - output channel (out_valid_o / out_stall_i / out_item_o): one item per render,
//   color plus opaque flag, in input order; writes and the unused opcode give nothing
// - config port: cfg_we_i writes cfg_wdata_i into register cfg_index_i (layer control,
//   scroll x, scroll y, mosaic size); write only while the block is idle
// - render path: the front registers the item, runs it through the remainder unit first
//   when mosaic is on (2 bits per cycle) and pushes it into the queue; the back end
//   then does three dependent reads (map entry, tile halfword, palette) through the
//   registered memory ports and registers the result; it pops a new command only
//   after its palette step; writes retire at one per cycle while the back end is idle
// - the front can take a new item while the back is busy, up to the queue depth
// - reset clears config, control and the queue; memories are not cleared and must be
//   written before they are read
// - a stalled output holds its item; the back end waits in its palette step and the
//   queue then the input fill up behind it
module tiled_bg_pixel_fetch_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [15:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tbg_pkg::tbg_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tbg_pkg::tbg_out_t out_item_o
);

  // configuration registers
  tbg_pkg::tbg_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tbg_pkg::REG_LAYER_CONTROL: cfg_q.layer_control <= cfg_wdata_i;
        tbg_pkg::REG_SCROLL_X:      cfg_q.scroll_x      <= cfg_wdata_i[8:0];
        tbg_pkg::REG_SCROLL_Y:      cfg_q.scroll_y      <= cfg_wdata_i[8:0];
        tbg_pkg::REG_MOSAIC_SIZE:   cfg_q.mosaic_size   <= cfg_wdata_i[7:0];
        default: begin
        end
      endcase
    end
  end

  // front to queue to back
  logic                    q_push, q_pop;
  tbg_pkg::tbg_cmd_t       push_cmd, pop_cmd;
  tbg_pkg::tbg_q_status_t  q_status;
  tbg_pkg::tbg_fr_status_t fr_status;
  tbg_pkg::tbg_bk_status_t bk_status;

  tbg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_status_i (q_status),
    .q_push_o   (q_push),
    .q_cmd_o    (push_cmd),
    .status_o   (fr_status)
  );

  tbg_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .cmd_i    (push_cmd),
    .pop_i    (q_pop),
    .cmd_o    (pop_cmd),
    .status_o (q_status)
  );

  tbg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_status_i  (q_status),
    .q_cmd_i     (pop_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .status_o    (bk_status)
  );

`ifndef SYNTH
  // queue occupancy never goes past its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.count <= tbg_pkg::QC_W'(tbg_pkg::QDEPTH))
    else $error("command queue overflow");

  // a new output item only comes out of the palette step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(bk_status.in_pal))
    else $error("output item without palette step");

  // an empty front never stalls the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fr_status.holding |-> !in_stall_o)
    else $error("input stalled with empty front");

  // nothing is pushed into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.full |-> !q_push)
    else $error("push into full queue");
`endif

endmodule

>>> dv/tb_tiled_bg_pixel_fetch_core.sv
`timescale 1ns / 1ps
// tb_tiled_bg_pixel_fetch_core: self-checking testbench of the tiled background pixel fetch
// drives write and render items under random idling and stalls, predicts every pixel item
// depends on tbg_pkg and tiled_bg_pixel_fetch_core
module tb_tiled_bg_pixel_fetch_core;
  import tbg_pkg::*;

  // the fourth opcode has no meaning, the block drops it
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int ITEM_GOAL    = 650;
  localparam int PHASE_ITEMS  = 70;
  // long enough for a write still trailing the last pixel to land
  localparam int DRAIN_CYCLES = 24;
  // longest correct quiet spell: a mosaic render behind a full queue plus a rare
  // run of stalls; the limit allows for it many times over
  localparam int QUIET_LIMIT  = 4000;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = REG_LAYER_CONTROL;
  logic [15:0] cfg_wdata_i = '0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  tbg_in_t  in_item_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  tbg_out_t out_item_o;

  tiled_bg_pixel_fetch_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the block: memories with a written flag per entry, and the layer registers
  bit [15:0] vid_mem [VIDEO_WORDS];
  bit        vid_written [VIDEO_WORDS];
  bit [14:0] pal_mem [PALETTE_ENTRIES];
  bit        pal_written [PALETTE_ENTRIES];
  logic [15:0] layer_ctl = '0;
  logic [8:0]  scroll_h = '0;
  logic [8:0]  scroll_v = '0;
  logic [7:0]  mosaic_blk = '0;

  tbg_out_t expected_pixels [$];
  int  errors = 0;
  int  items_sent = 0;
  int  pixels_checked = 0;
  int  layers_applied = 0;
  int  quiet_cycles = 0;
  bit  calm = 1'b0;

  // walk one pixel through mosaic, scroll, quadrant, map entry, tile byte and palette;
  // also hands back the three addresses it touched so callers can fill them first
  function automatic void trace_pixel(input logic [7:0] col, input logic [7:0] line,
                                      output logic [VA_W-1:0] map_a,
                                      output logic [VA_W-1:0] chr_a,
                                      output logic [7:0] pal_i, output bit pal_used,
                                      output tbg_out_t px);
    int unsigned x, y, mh, mv, xx, yy, map_addr, tile, bank, tx, ty, bpp, byte_a, pix;
    logic [15:0] entry, hw;
    bit eight;
    begin
      x = col;
      y = line;
      eight = layer_ctl[LC_EIGHT];
      bpp = eight ? 8 : 4;
      if (layer_ctl[LC_MOSAIC]) begin
        mh = mosaic_blk[3:0] + 1;
        mv = mosaic_blk[7:4] + 1;
        x = x - x % mh;
        y = y - y % mv;
      end
      xx = (x + scroll_h) & 32'h1FF;
      yy = (y + scroll_v) & 32'h1FF;
      // screen blocks of 32x32 entries, right half first, then the lower half
      map_addr = layer_ctl[12:8] * 32'h400;
      if (xx > 255 && layer_ctl[LC_WIDE]) begin
        map_addr = map_addr + 32'h400;
      end
      if (yy > 255 && layer_ctl[LC_TALL]) begin
        map_addr = map_addr + (layer_ctl[LC_WIDE] ? 32'h800 : 32'h400);
      end
      xx = xx & 32'hFF;
      yy = yy & 32'hFF;
      map_addr = map_addr + (yy >> 3) * 32 + (xx >> 3);
      map_a = map_addr[VA_W-1:0];
      entry = vid_mem[map_a];
      tile = entry[9:0];
      bank = entry[15:12];
      tx = xx & 7;
      ty = yy & 7;
      if (entry[10]) begin
        tx = 7 - tx;
      end
      if (entry[11]) begin
        ty = 7 - ty;
      end
      byte_a = layer_ctl[3:2] * 32'h4000 + tile * (bpp * 8) + ty * bpp
             + (eight ? tx : (tx >> 1));
      chr_a = byte_a[VA_W:1];
      hw = vid_mem[chr_a];
      pix = byte_a[0] ? hw[15:8] : hw[7:0];
      if (!eight) begin
        pix = tx[0] ? (pix >> 4) : (pix & 32'hF);
      end
      // index zero is see-through in both depths
      pal_i = eight ? pix[7:0] : {bank[3:0], pix[3:0]};
      pal_used = (pix != 0);
      px.color = pal_used ? pal_mem[pal_i] : '0;
      px.opaque = pal_used;
    end
  endfunction

  // tile data with plenty of zero nibbles so see-through pixels are common
  function automatic logic [15:0] speckled();
    logic [15:0] v;
    begin
      for (int k = 0; k < 4; k++) begin
        v[4*k +: 4] = ($urandom_range(0, 3) == 0) ? 4'h0 : 4'($urandom_range(0, 15));
      end
      return v;
    end
  endfunction

  // zero, the top value or anything between
  function automatic int unsigned pick_level(input int unsigned top);
    begin
      case ($urandom_range(0, 3))
        0: return 0;
        1: return top;
        default: return $urandom_range(0, top);
      endcase
    end
  endfunction

  // one item across the input channel; the shadow moves on at the edge that takes it
  task automatic send_item(input tbg_in_t item);
    tbg_out_t px;
    logic [VA_W-1:0] ma, ca;
    logic [7:0] pi;
    bit pu;
    begin
      while (!calm && $urandom_range(0, 99) < 17) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      in_item_i <= item;
      @(posedge clk_i);
      while (in_stall_o !== 1'b0) begin
        @(posedge clk_i);
      end
      case (item.opcode)
        OP_VID_WR: begin
          vid_mem[item.mem_address] = item.write_value;
          vid_written[item.mem_address] = 1'b1;
          items_sent++;
        end
        OP_PAL_WR: begin
          pal_mem[item.mem_address[PA_W-1:0]] = item.write_value[14:0];
          pal_written[item.mem_address[PA_W-1:0]] = 1'b1;
          items_sent++;
        end
        OP_RENDER: begin
          trace_pixel(item.column, item.screen_line, ma, ca, pi, pu, px);
          expected_pixels.push_back(px);
          items_sent++;
        end
        default: begin
        end
      endcase
    end
  endtask

  task automatic store_halfword(input logic [14:0] addr, input logic [15:0] val);
    tbg_in_t item;
    begin
      item.opcode = OP_VID_WR;
      item.mem_address = addr;
      item.write_value = val;
      item.column = 8'($urandom);
      item.screen_line = 8'($urandom);
      send_item(item);
    end
  endtask

  task automatic store_color(input logic [14:0] addr, input logic [15:0] val);
    tbg_in_t item;
    begin
      item.opcode = OP_PAL_WR;
      item.mem_address = addr;
      item.write_value = val;
      item.column = 8'($urandom);
      item.screen_line = 8'($urandom);
      send_item(item);
    end
  endtask

  task automatic send_unused(input tbg_in_t item);
    begin
      item.opcode = OP_UNUSED;
      send_item(item);
    end
  endtask

  // render one pixel; every map entry, tile halfword and palette entry it reads gets
  // written first, and with blank set its tile halfword is cleared to zero
  task automatic draw_pixel(input logic [7:0] col, input logic [7:0] line, input bit blank);
    tbg_in_t item;
    tbg_out_t px;
    logic [VA_W-1:0] ma, ca;
    logic [7:0] pi;
    bit pu, blanked, ready;
    begin
      blanked = 1'b0;
      ready = 1'b0;
      while (!ready) begin
        trace_pixel(col, line, ma, ca, pi, pu, px);
        if (!vid_written[ma]) begin
          store_halfword(ma, 16'($urandom));
        end else if (blank && !blanked) begin
          store_halfword(ca, 16'h0000);
          blanked = 1'b1;
        end else if (!vid_written[ca]) begin
          store_halfword(ca, speckled());
        end else if (pu && !pal_written[pi]) begin
          store_color({7'($urandom), pi}, 16'($urandom));
        end else begin
          ready = 1'b1;
        end
      end
      item.opcode = OP_RENDER;
      item.mem_address = 15'($urandom);
      item.write_value = 16'($urandom);
      item.column = col;
      item.screen_line = line;
      send_item(item);
    end
  endtask

  // stop sending, let every pixel come out, then give trailing writes time to land
  task automatic settle();
    begin
      in_valid_i <= 1'b0;
      while (expected_pixels.size() != 0) begin
        @(posedge clk_i);
      end
      repeat (DRAIN_CYCLES) @(posedge clk_i);
    end
  endtask

  // leaves the write enable high; the caller lowers it after the last register
  task automatic poke_reg(input logic [1:0] idx, input logic [15:0] val);
    begin
      cfg_we_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_wdata_i <= val;
      @(posedge clk_i);
    end
  endtask

  task automatic apply_layer(input logic [15:0] ctl, input logic [8:0] sx,
                             input logic [8:0] sy, input logic [7:0] mos);
    begin
      poke_reg(REG_LAYER_CONTROL, ctl);
      poke_reg(REG_SCROLL_X, {7'd0, sx});
      poke_reg(REG_SCROLL_Y, {7'd0, sy});
      poke_reg(REG_MOSAIC_SIZE, {8'd0, mos});
      cfg_we_i <= 1'b0;
      layer_ctl = ctl;
      scroll_h = sx;
      scroll_v = sy;
      mosaic_blk = mos;
      layers_applied++;
    end
  endtask

  // address and value extremes, palette index wraps to 255 and drops the top bit
  task automatic test_write_extremes();
    begin
      store_halfword(15'h7FFF, 16'h0000);
      store_halfword(15'h0000, 16'hFFFF);
      store_color(15'h7FFF, 16'hFFFF);
    end
  endtask

  // reset layer: 4bpp, block zero; corner entry holds both flips, bank 15, last tile
  task automatic test_corner_pixels();
    begin
      draw_pixel(8'd0, 8'd0, 1'b0);
      draw_pixel(8'd255, 8'd255, 1'b0);
      draw_pixel(8'd3, 8'd5, 1'b1);
    end
  endtask

  task automatic test_unused_opcode();
    begin
      send_unused('1);
      send_unused('0);
    end
  endtask

  // 8bpp: a zero byte must come out see-through, like in 4bpp
  task automatic test_eight_bpp_transparency();
    begin
      settle();
      apply_layer(16'h0080, 9'd0, 9'd0, 8'h00);
      draw_pixel(8'd8, 8'd0, 1'b1);
      draw_pixel(8'd250, 8'd250, 1'b0);
    end
  endtask

  // top screen base with both halves set runs past the end of video memory;
  // then each half on its own with scroll pushing into the second quadrant
  task automatic test_wrap_and_quadrants();
    begin
      settle();
      apply_layer(16'hFFFF, 9'h1FF, 9'h1FF, 8'h00);
      draw_pixel(8'd0, 8'd0, 1'b0);
      draw_pixel(8'd100, 8'd2, 1'b0);
      settle();
      apply_layer(16'h4000, 9'd300, 9'd260, 8'h00);
      draw_pixel(8'd60, 8'd7, 1'b0);
      settle();
      apply_layer(16'h8000, 9'd300, 9'd260, 8'h00);
      draw_pixel(8'd60, 8'd7, 1'b0);
    end
  endtask

  // largest blocks, then uneven ones
  task automatic test_mosaic();
    begin
      settle();
      apply_layer(16'h0040, 9'd5, 9'd3, 8'hFF);
      draw_pixel(8'd200, 8'd100, 1'b0);
      settle();
      apply_layer(16'h0044, 9'd0, 9'd0, 8'h3A);
      draw_pixel(8'd17, 8'd33, 1'b0);
    end
  endtask

  // random layer settings; most items render, the rest rewrite memory or are junk
  task automatic test_random_layers();
    tbg_in_t item;
    tbg_out_t px;
    logic [VA_W-1:0] ma, ca;
    logic [7:0] pi;
    bit pu;
    int phase;
    int r;
    begin
      phase = 0;
      while (items_sent < ITEM_GOAL) begin
        settle();
        apply_layer(16'(pick_level(16'hFFFF)), 9'(pick_level(511)), 9'(pick_level(511)),
                    8'(pick_level(255)));
        // one phase runs with no idling on either side
        calm = (phase == 3);
        repeat (PHASE_ITEMS) begin
          r = $urandom_range(0, 99);
          if (r < 62) begin
            draw_pixel(8'($urandom), 8'($urandom), r < 4);
          end else if (r < 74) begin
            store_halfword(15'($urandom), 16'($urandom));
          end else if (r < 86) begin
            store_color(15'($urandom), 16'($urandom));
          end else if (r < 94) begin
            // new map entry under some pixel, so its tile and flips change
            trace_pixel(8'($urandom), 8'($urandom), ma, ca, pi, pu, px);
            store_halfword(ma, 16'($urandom));
          end else begin
            item = tbg_in_t'({$urandom, $urandom});
            send_unused(item);
          end
        end
        calm = 1'b0;
        phase++;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_write_extremes();
    test_corner_pixels();
    test_unused_opcode();
    test_eight_bpp_transparency();
    test_wrap_and_quadrants();
    test_mosaic();
    test_random_layers();
    settle();
    $display("pixel fetch run: %0d items sent, %0d pixels compared over %0d layer settings",
             items_sent, pixels_checked, layers_applied);
    $display("covered corners, flips, quadrants, address wrap, mosaic and both depths");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // result side stalls at random, except in the calm phase
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 17);
  end

  // compare each pixel item with the oldest prediction
  always @(posedge clk_i) begin : check_pixels
    tbg_out_t want;
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      if (expected_pixels.size() == 0) begin
        errors++;
        $display("%0t: pixel item with none expected, color %h opaque %b",
                 $time, out_item_o.color, out_item_o.opaque);
      end else begin
        want = expected_pixels.pop_front();
        pixels_checked++;
        if (out_item_o.color !== want.color) begin
          errors++;
          $display("%0t: color mismatch, expected %h got %h",
                   $time, want.color, out_item_o.color);
        end
        if (out_item_o.opaque !== want.opaque) begin
          errors++;
          $display("%0t: opaque mismatch, expected %b got %b",
                   $time, want.opaque, out_item_o.opaque);
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no item moved for %0d cycles, %0d pixels outstanding",
               $time, quiet_cycles, expected_pixels.size());
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule

>>> files.f
src/tbg_pkg.sv
src/tbg_ram.sv
src/tbg_queue.sv
src/tbg_front.sv
src/tbg_back.sv
src/tiled_bg_pixel_fetch_core.sv
dv/tb_tiled_bg_pixel_fetch_core.sv
